@@ hw/rtl/azimuthal_equidistant_projection_unit_defines.svh @@
// Assertion helpers for the projection unit.
`ifndef AZIMUTHAL_EQUIDISTANT_PROJECTION_UNIT_DEFINES_SVH
`define AZIMUTHAL_EQUIDISTANT_PROJECTION_UNIT_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define AEP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define AEP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/aep_pkg.sv @@
`timescale 1ns / 1ps
package aep_pkg;

    // Field widths
    localparam int LON_W      = 29;
    localparam int LAT_W      = 28;
    localparam int RAD_W      = 23;
    localparam int OUT_W      = 29;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Datapath widths
    localparam int PH_W   = 32;         // binary phase, full turn = 2^32
    localparam int ROT_W  = 32;         // Q30 sine/cosine values
    localparam int RZ_W   = PH_W + 1;   // rotation angle accumulator
    localparam int VEC_W  = 36;         // vectoring x/y
    localparam int VZ_W   = 34;         // vectoring angle accumulator
    localparam int MQ_W   = 2 * ROT_W - 30;
    localparam int ATAN_W = 30;
    localparam int ITERS  = 24;         // CORDIC iterations

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_LON   = 2'd0,
        REG_CENTER_LAT   = 2'd1,
        REG_EARTH_RADIUS = 2'd2
    } cfg_reg_t;

    typedef logic signed [ROT_W-1:0] q30_t;
    typedef logic signed [VEC_W-1:0] vec_t;
    typedef logic signed [VZ_W-1:0]  vang_t;

    localparam logic [RAD_W-1:0] RADIUS_RESET = 23'd6378137;

    localparam q30_t GAIN_Q30 = 32'sd652032874;
    localparam logic signed [2*ROT_W-1:0] Q30_HALF = 64'sd536870912;

    localparam logic signed [RZ_W-1:0] ROT_QUARTER = 33'sh040000000;
    localparam logic signed [RZ_W-1:0] ROT_HALF    = 33'sh080000000;
    localparam vang_t VEC_HALF = 34'sh080000000;

    // pi * 2^32, rounded
    localparam int PI_W = 34;
    localparam logic [PI_W-1:0] PI_Q32 = 34'd13493037705;

    // Degree-to-phase: q = floor((mag*512 + 22) / 45), split as mag = 45a + b
    localparam int REC45_W     = 30;
    localparam int REC45_SH    = 35;
    localparam logic [REC45_W-1:0] REC45 = 30'd763549742;
    localparam int REC45S_W    = 16;
    localparam int REC45S_SH   = 21;
    localparam logic [REC45S_W-1:0] REC45_S = 16'd46604;
    localparam logic [5:0] DIV_C = 6'd45;

    // atan(2^-i) as phase
    localparam logic [ATAN_W-1:0] ATAN_TAB [0:31] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
        30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
        30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
        30'd166886,    30'd83443,     30'd41722,     30'd20861,
        30'd10430,     30'd5215,      30'd2608,      30'd1304,
        30'd652,       30'd326,       30'd163,       30'd81,
        30'd41,        30'd20,        30'd10,        30'd5,
        30'd3,         30'd1,         30'd1,         30'd0
    };

    // Q30 product, rounded to nearest, halves up
    function automatic logic signed [MQ_W-1:0] q30_mul(input q30_t a, input q30_t b);
        logic signed [2*ROT_W-1:0] p;
        p = a * b;
        p = p + Q30_HALF;
        return p[2*ROT_W-1:30];
    endfunction

endpackage

@@ hw/rtl/aep_cordic_rot.sv @@
`timescale 1ns / 1ps
// Pipelined CORDIC rotation: phase in, Q30 sine and cosine out.
module aep_cordic_rot (
    input  logic                     clk,
    input  logic                     en,
    input  logic [aep_pkg::PH_W-1:0] phase,
    output aep_pkg::q30_t            sin_out,
    output aep_pkg::q30_t            cos_out
);
    import aep_pkg::*;

    q30_t                   x_reg    [0:ITERS];
    q30_t                   y_reg    [0:ITERS];
    logic signed [RZ_W-1:0] z_reg    [0:ITERS];
    logic                   flip_reg [0:ITERS];
    q30_t                   sin_reg;
    q30_t                   cos_reg;

    logic signed [RZ_W-1:0] z_in;
    logic signed [RZ_W-1:0] z_fold;
    logic                   flip_in;

    // Fold into the right half plane
    always_comb
    begin
        z_in    = $signed({phase[PH_W-1], phase});
        z_fold  = z_in;
        flip_in = 1'b0;
        if (z_in > ROT_QUARTER)
        begin
            z_fold  = z_in - ROT_HALF;
            flip_in = 1'b1;
        end
        else if (z_in < -ROT_QUARTER)
        begin
            z_fold  = z_in + ROT_HALF;
            flip_in = 1'b1;
        end
    end

    // Fold stage, iteration stages, output stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= GAIN_Q30;
            y_reg[0]    <= '0;
            z_reg[0]    <= z_fold;
            flip_reg[0] <= flip_in;
            for (int i = 0; i < ITERS; i++)
            begin
                if (!z_reg[i][RZ_W-1])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - $signed({{(RZ_W-ATAN_W){1'b0}}, ATAN_TAB[i]});
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + $signed({{(RZ_W-ATAN_W){1'b0}}, ATAN_TAB[i]});
                end
                flip_reg[i+1] <= flip_reg[i];
            end
            cos_reg <= flip_reg[ITERS] ? -x_reg[ITERS] : x_reg[ITERS];
            sin_reg <= flip_reg[ITERS] ? -y_reg[ITERS] : y_reg[ITERS];
        end
    end

    assign sin_out = sin_reg;
    assign cos_out = cos_reg;

endmodule

@@ hw/rtl/aep_cordic_vec.sv @@
`timescale 1ns / 1ps
// Pipelined CORDIC vectoring: atan2(y, x) as phase and unscaled magnitude.
module aep_cordic_vec (
    input  logic           clk,
    input  logic           en,
    input  aep_pkg::vec_t  x_in,
    input  aep_pkg::vec_t  y_in,
    output aep_pkg::vec_t  mag_out,
    output aep_pkg::vang_t ang_out
);
    import aep_pkg::*;

    vec_t  x_reg [0:ITERS];
    vec_t  y_reg [0:ITERS];
    vang_t z_reg [0:ITERS];

    // Pre-rotation of left half plane, then iterations
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (x_in[VEC_W-1])
            begin
                x_reg[0] <= -x_in;
                y_reg[0] <= -y_in;
                z_reg[0] <= VEC_HALF;
            end
            else
            begin
                x_reg[0] <= x_in;
                y_reg[0] <= y_in;
                z_reg[0] <= '0;
            end
            for (int i = 0; i < ITERS; i++)
            begin
                if (y_reg[i][VEC_W-1])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - $signed({{(VZ_W-ATAN_W){1'b0}}, ATAN_TAB[i]});
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + $signed({{(VZ_W-ATAN_W){1'b0}}, ATAN_TAB[i]});
                end
            end
        end
    end

    assign mag_out = x_reg[ITERS];
    assign ang_out = z_reg[ITERS];

endmodule

@@ hw/rtl/azimuthal_equidistant_projection_unit.sv @@
// Pipeline: 87 register stages.
// Throughput: one request per cycle while not stalled; a single valid chain moves on one enable,
// so a held result stalls every stage and in_ready = !out_valid | out_ready.
// Reset: valid chain cleared, center at (0,0), earth radius 6378137 m.
// Center writes apply to items accepted later; radius writes also reach items in flight.
`timescale 1ns / 1ps
`include "azimuthal_equidistant_projection_unit_defines.svh"
module azimuthal_equidistant_projection_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [aep_pkg::LON_W-1:0]      lon_deg,
    input  logic signed [aep_pkg::LAT_W-1:0]      lat_deg,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [aep_pkg::OUT_W-1:0]      x_east,
    output logic signed [aep_pkg::OUT_W-1:0]      y_south,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [aep_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [aep_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import aep_pkg::*;

    localparam int LAT_TOTAL = 87;
    localparam int V1_STAGE  = 58;
    localparam int NLANE     = 4;
    localparam int PROD_W    = LON_W + REC45_W;
    localparam int A_W       = PROD_W - REC45_SH;
    localparam int C_W       = 15;
    localparam int CP_W      = C_W + REC45S_W;
    localparam int CC_DLY    = 26;
    localparam int K_FULL_W  = RAD_W + PI_W;
    localparam int K_W       = K_FULL_W - 25;
    localparam int XS_FULL_W = VZ_W + ROT_W;
    localparam int XO_FULL_W = VZ_W + K_W + 1;
    localparam logic signed [XS_FULL_W-1:0] XS_HALF = 66'sd536870912;
    localparam logic signed [XO_FULL_W-1:0] XO_HALF = 67'sd17179869184;
    localparam logic signed [VEC_W+ROT_W-1:0] G_HALF = 68'sd536870912;
    localparam logic signed [ROT_W:0] ONE_Q30 = 33'sd1073741824;

    // Configuration registers
    logic signed [LON_W-1:0] center_lon_reg;
    logic signed [LAT_W-1:0] center_lat_reg;
    logic [RAD_W-1:0]        earth_radius_reg;
    logic [K_FULL_W-1:0]     k7_full;
    logic [K_W-1:0]          k7_reg;

    // Pipeline control
    logic [LAT_TOTAL:1] v_reg;
    logic               en;

    // Phase conversion lanes: lon, lat, center lon, center lat
    logic signed [LON_W-1:0] cv_in      [0:NLANE-1];
    logic                    c1_neg_reg [0:NLANE-1];
    logic [LON_W-1:0]        c1_mag_reg [0:NLANE-1];
    logic                    c2_neg_reg [0:NLANE-1];
    logic [LON_W-1:0]        c2_mag_reg [0:NLANE-1];
    logic [PROD_W-1:0]       c2_prod_reg[0:NLANE-1];
    logic                    c3_neg_reg [0:NLANE-1];
    logic [A_W-1:0]          c3_a_reg   [0:NLANE-1];
    logic [5:0]              c3_b_reg   [0:NLANE-1];
    logic [PH_W-1:0]         phase_reg  [0:NLANE-1];
    logic [PH_W-1:0]         dlon_phase;

    // Trig results
    q30_t s_lat, c_lat, s_lat0, c_lat0, s_d, c_d, s_t, c_t;

    // Product stages
    q30_t p1_reg, p2_reg, p3_reg, p4_reg, p5_reg, cd_reg;
    q30_t m2_p1_reg, m2_p3_reg, m2_p4_reg, q2_reg, q5_reg;
    logic signed [ROT_W:0] cc_sum;
    q30_t                  cc_reg;
    q30_t                  num_reg;
    logic signed [ROT_W:0] den_reg;
    q30_t                  cc_dly [0:CC_DLY-1];

    // Vectoring
    vec_t  vec1_x, vec2_mag;
    vang_t vec1_z, vec2_z;
    logic signed [VEC_W+ROT_W-1:0] g_prod;
    vec_t            sin_rho_reg;
    logic [PH_W-1:0] theta_reg;
    vang_t           rho_reg;

    // Final scaling
    logic signed [XS_FULL_W-1:0] xs_full, ys_full;
    vang_t                       xs_reg, ys_reg;
    logic signed [XO_FULL_W-1:0] xo_full, yo_full;
    logic signed [OUT_W-1:0]     x_east_reg, y_south_reg;

    // Config write port
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_lon_reg   <= '0;
            center_lat_reg   <= '0;
            earth_radius_reg <= RADIUS_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_CENTER_LON:   center_lon_reg   <= cfg_data[LON_W-1:0];
                REG_CENTER_LAT:   center_lat_reg   <= cfg_data[LAT_W-1:0];
                REG_EARTH_RADIUS: earth_radius_reg <= cfg_data[RAD_W-1:0];
                default: ;
            endcase
        end
    end

    // Distance scale K = round(radius * pi * 2^32 / 2^25)
    assign k7_full = K_FULL_W'(earth_radius_reg) * K_FULL_W'(PI_Q32)
                   + (K_FULL_W'(1) << 24);

    always_ff @(posedge clk)
    begin
        k7_reg <= k7_full[K_FULL_W-1:25];
    end

    // Valid chain
    assign en        = !v_reg[LAT_TOTAL] || out_ready;
    assign in_ready  = en;
    assign out_valid = v_reg[LAT_TOTAL];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[LAT_TOTAL-1:1], in_valid};
        end
    end

    // Degree to phase conversion, four stages
    assign cv_in[0] = lon_deg;
    assign cv_in[1] = LON_W'(lat_deg);
    assign cv_in[2] = center_lon_reg;
    assign cv_in[3] = LON_W'(center_lat_reg);

    always_ff @(posedge clk)
    begin
        logic [LON_W-1:0] b_full;
        logic [C_W-1:0]   c_val;
        logic [CP_W-1:0]  c_prod;
        logic [PH_W:0]    q_val;
        if (en)
        begin
            for (int l = 0; l < NLANE; l++)
            begin
                c1_neg_reg[l] <= cv_in[l][LON_W-1];
                c1_mag_reg[l] <= cv_in[l][LON_W-1] ? LON_W'(-cv_in[l]) : cv_in[l];

                c2_neg_reg[l]  <= c1_neg_reg[l];
                c2_mag_reg[l]  <= c1_mag_reg[l];
                c2_prod_reg[l] <= PROD_W'(c1_mag_reg[l]) * PROD_W'(REC45);

                b_full = c2_mag_reg[l]
                       - LON_W'(c2_prod_reg[l][PROD_W-1:REC45_SH]) * LON_W'(DIV_C);
                c3_neg_reg[l] <= c2_neg_reg[l];
                c3_a_reg[l]   <= c2_prod_reg[l][PROD_W-1:REC45_SH];
                c3_b_reg[l]   <= b_full[5:0];

                c_val  = {c3_b_reg[l], 9'd0} + C_W'(22);
                c_prod = CP_W'(c_val) * CP_W'(REC45_S);
                q_val  = {c3_a_reg[l], 9'd0} + (PH_W+1)'(c_prod[CP_W-1:REC45S_SH]);
                phase_reg[l] <= c3_neg_reg[l] ? -q_val[PH_W-1:0] : q_val[PH_W-1:0];
            end
        end
    end

    assign dlon_phase = phase_reg[0] - phase_reg[2];

    // Sine and cosine of lat, center lat, and lon difference
    aep_cordic_rot u_rot_lat (
        .clk(clk), .en(en), .phase(phase_reg[1]), .sin_out(s_lat), .cos_out(c_lat)
    );
    aep_cordic_rot u_rot_lat0 (
        .clk(clk), .en(en), .phase(phase_reg[3]), .sin_out(s_lat0), .cos_out(c_lat0)
    );
    aep_cordic_rot u_rot_dlon (
        .clk(clk), .en(en), .phase(dlon_phase), .sin_out(s_d), .cos_out(c_d)
    );

    // Spherical terms over three product stages
    assign cc_sum = (ROT_W+1)'(m2_p1_reg) + (ROT_W+1)'(q2_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg <= ROT_W'(q30_mul(s_lat0, s_lat));
            p2_reg <= ROT_W'(q30_mul(c_lat0, c_lat));
            p3_reg <= ROT_W'(q30_mul(c_lat, s_d));
            p4_reg <= ROT_W'(q30_mul(c_lat0, s_lat));
            p5_reg <= ROT_W'(q30_mul(s_lat0, c_lat));
            cd_reg <= c_d;

            m2_p1_reg <= p1_reg;
            m2_p3_reg <= p3_reg;
            m2_p4_reg <= p4_reg;
            q2_reg    <= ROT_W'(q30_mul(p2_reg, cd_reg));
            q5_reg    <= ROT_W'(q30_mul(p5_reg, cd_reg));

            // cos(rho) clamped to [-1, 1]
            if (cc_sum > ONE_Q30)
                cc_reg <= ROT_W'(ONE_Q30);
            else if (cc_sum < -ONE_Q30)
                cc_reg <= ROT_W'(-ONE_Q30);
            else
                cc_reg <= ROT_W'(cc_sum);
            num_reg <= m2_p3_reg;
            den_reg <= (ROT_W+1)'(m2_p4_reg) - (ROT_W+1)'(q5_reg);
        end
    end

    // Bearing and sin(rho)
    aep_cordic_vec u_vec_bearing (
        .clk(clk), .en(en),
        .x_in(VEC_W'(den_reg)), .y_in(VEC_W'(num_reg)),
        .mag_out(vec1_x), .ang_out(vec1_z)
    );

    assign g_prod = vec1_x * GAIN_Q30 + G_HALF;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cc_dly[0] <= cc_reg;
            for (int i = 1; i < CC_DLY; i++)
            begin
                cc_dly[i] <= cc_dly[i-1];
            end
            sin_rho_reg <= g_prod[VEC_W+30-1:30];
            theta_reg   <= vec1_z[PH_W-1:0];
        end
    end

    // rho = atan2(sin rho, cos rho)
    aep_cordic_vec u_vec_rho (
        .clk(clk), .en(en),
        .x_in(VEC_W'(cc_dly[CC_DLY-1])), .y_in(sin_rho_reg),
        .mag_out(vec2_mag), .ang_out(vec2_z)
    );

    // sin/cos of bearing
    aep_cordic_rot u_rot_theta (
        .clk(clk), .en(en), .phase(theta_reg), .sin_out(s_t), .cos_out(c_t)
    );

    // Final scaling to 1/8 metre
    assign xs_full = rho_reg * s_t + XS_HALF;
    assign ys_full = rho_reg * c_t + XS_HALF;
    assign xo_full = xs_reg * $signed({1'b0, k7_reg}) + XO_HALF;
    assign yo_full = ys_reg * $signed({1'b0, k7_reg}) + XO_HALF;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rho_reg     <= vec2_z;
            xs_reg      <= xs_full[30+VZ_W-1:30];
            ys_reg      <= ys_full[30+VZ_W-1:30];
            x_east_reg  <= xo_full[35+OUT_W-1:35];
            y_south_reg <= -yo_full[35+OUT_W-1:35];
        end
    end

    assign x_east  = x_east_reg;
    assign y_south = y_south_reg;

    // Checks
    `AEP_ASSERT_NEXT(a_accept_enters, in_valid && in_ready, v_reg[1], "accepted request lost")
    `AEP_ASSERT_NEXT(a_stall_holds, !en, $stable(v_reg), "valid chain moved during stall")
    `AEP_ASSERT_SAME(a_vec_mag_pos, v_reg[V1_STAGE] && !vec2_mag[VEC_W-1], !vec1_x[VEC_W-1], "bearing magnitude negative")

endmodule
